// ----- src/fwc_pkg.sv -----
// ----------------------------------------------------------------------------
// fwc_pkg
// Shared types and constants of the feathered wipe compositor: sweep
// direction codes, register indexes, field widths and the config bundle.
// ----------------------------------------------------------------------------
package fwc_pkg;

  // Field widths
  localparam int EDGE_W    = 11;
  localparam int FEATHER_W = 7;
  localparam int WBYTES_W  = 8;
  localparam int HEIGHT_W  = 10;
  localparam int ROW_W     = 9;
  localparam int COL_W     = 7;
  localparam int PIX_W     = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 11;

  // Frame width in pixels, band start and sweep position
  localparam int SPAN_W = WBYTES_W + 3;
  localparam int BAND_W = EDGE_W + 1;
  localparam int POS_W  = SPAN_W + 2;

  // Leftmost pixel of a byte
  localparam logic [PIX_W-1:0] PIX_MSB = 8'h80;

  // Reset values
  localparam logic [WBYTES_W-1:0] WBYTES_RESET = 8'd100;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 10'd480;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIPE_EDGE    = 3'd0,
    REG_FEATHER      = 3'd1,
    REG_DIRECTION    = 3'd2,
    REG_WIDTH_BYTES  = 3'd3,
    REG_HEIGHT       = 3'd4
  } reg_idx_t;

  // Sweep directions
  typedef enum logic [1:0] {
    SWEEP_R2L = 2'd0,  // pos = x
    SWEEP_L2R = 2'd1,  // pos = W-1-x
    SWEEP_B2T = 2'd2,  // pos = row
    SWEEP_T2B = 2'd3   // pos = H-1-row
  } sweep_dir_t;

  // Derived configuration seen by the datapath
  typedef struct packed {
    logic [EDGE_W-1:0]        edge_pos;
    logic signed [BAND_W-1:0] band_start;
    sweep_dir_t               dir;
    logic [SPAN_W-1:0]        width_pix;
    logic [HEIGHT_W-1:0]      height_rows;
    logic                     edge_zero;
    logic                     edge_past;
  } cfg_t;

endpackage

// ----- src/fwc_config.sv -----
// ----------------------------------------------------------------------------
// fwc_config
// Configuration register file with saturation of the frame size and the
// derived band start, span and whole-byte bypass flags.
// ----------------------------------------------------------------------------
module fwc_config #(
  parameter int MAX_WIDTH_BYTES = 128,
  parameter int MAX_HEIGHT      = 512
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [fwc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fwc_pkg::CFG_DAT_W-1:0]    cfg_data,
  output fwc_pkg::cfg_t                    cfg
);
  import fwc_pkg::*;

  logic [EDGE_W-1:0]    wipe_edge;
  logic [FEATHER_W-1:0] feather_width;
  sweep_dir_t           sweep_direction;
  logic [WBYTES_W-1:0]  frame_width_bytes;
  logic [HEIGHT_W-1:0]  frame_height;

  logic [WBYTES_W-1:0]  wb;
  logic [HEIGHT_W-1:0]  hh;
  logic [SPAN_W-1:0]    span;

  // Write registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      wipe_edge         <= '0;
      feather_width     <= '0;
      sweep_direction   <= SWEEP_R2L;
      frame_width_bytes <= WBYTES_RESET;
      frame_height      <= HEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_WIPE_EDGE:   wipe_edge         <= cfg_data[EDGE_W-1:0];
        REG_FEATHER:     feather_width     <= cfg_data[FEATHER_W-1:0];
        REG_DIRECTION:   sweep_direction   <= sweep_dir_t'(cfg_data[1:0]);
        REG_WIDTH_BYTES: frame_width_bytes <= cfg_data[WBYTES_W-1:0];
        REG_HEIGHT:      frame_height      <= cfg_data[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturate frame size and derive span and flags
  always_comb begin
    wb = (int'(frame_width_bytes) > MAX_WIDTH_BYTES) ? WBYTES_W'(MAX_WIDTH_BYTES)
                                                     : frame_width_bytes;
    hh = (int'(frame_height) > MAX_HEIGHT) ? HEIGHT_W'(MAX_HEIGHT) : frame_height;
    cfg.width_pix   = {wb, 3'b000};
    cfg.height_rows = hh;
    span = (sweep_direction == SWEEP_R2L || sweep_direction == SWEEP_L2R)
           ? cfg.width_pix : SPAN_W'(hh);
    cfg.edge_pos   = wipe_edge;
    cfg.band_start = $signed({1'b0, wipe_edge})
                   - $signed({{(BAND_W-FEATHER_W){1'b0}}, feather_width});
    cfg.dir        = sweep_direction;
    cfg.edge_zero  = (wipe_edge == '0);
    cfg.edge_past  = (wipe_edge >= span);
  end

endmodule

// ----- src/feathered_wipe_compositor.sv -----
// ----------------------------------------------------------------------------
// feathered_wipe_compositor
// Composes one byte of a 1-bit wipe transition frame from old and new bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the src channel (row_index, byte_column, old_byte,
//   new_byte) and are taken at an edge with src_valid high and src_stall low.
//   Each request yields one composed_byte on the dst channel, taken at an
//   edge with dst_valid high and dst_stall low.
//   Throughput: one byte per cycle while dst is not stalled, through a
//   four-register pipeline (input capture, base sweep position, per-pixel
//   band compare, output select) that ends in the output register.
//   A stall on dst holds the output register; bubbles upstream still close
//   up, and src_stall rises only once every stage is full.
//   Configuration is written through cfg_write/cfg_index/cfg_data and must
//   change only while no request is in flight; unknown indexes are dropped.
//   Reset clears the pipeline valids and loads the register defaults
//   (edge 0, feather 0, right-to-left, 100 bytes by 480 rows).
// ----------------------------------------------------------------------------
module feathered_wipe_compositor #(
  parameter int MAX_WIDTH_BYTES = 128,
  parameter int MAX_HEIGHT      = 512
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [fwc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fwc_pkg::CFG_DAT_W-1:0] cfg_data,
  input  logic                          src_valid,
  output logic                          src_stall,
  input  logic [fwc_pkg::ROW_W-1:0]     row_index,
  input  logic [fwc_pkg::COL_W-1:0]     byte_column,
  input  logic [fwc_pkg::PIX_W-1:0]     old_byte,
  input  logic [fwc_pkg::PIX_W-1:0]     new_byte,
  output logic                          dst_valid,
  input  logic                          dst_stall,
  output logic [fwc_pkg::PIX_W-1:0]     composed_byte
);
  import fwc_pkg::*;

  cfg_t cfg;

  // Stage 1: captured request
  logic             s1_valid;
  logic [ROW_W-1:0] s1_row;
  logic [COL_W-1:0] s1_col;
  logic [PIX_W-1:0] s1_old;
  logic [PIX_W-1:0] s1_new;

  // Stage 2: base sweep position of the leftmost pixel
  logic                    s2_valid;
  logic signed [POS_W-1:0] s2_pos;
  logic [PIX_W-1:0]        s2_old;
  logic [PIX_W-1:0]        s2_new;

  // Stage 3: per-pixel new-page select mask
  logic             s3_valid;
  logic [PIX_W-1:0] s3_sel;
  logic [PIX_W-1:0] s3_old;
  logic [PIX_W-1:0] s3_new;

  logic out_ready, s3_ready, s2_ready, s1_ready;

  logic signed [POS_W-1:0] pos_next;
  logic [PIX_W-1:0]        sel_next;
  logic [PIX_W-1:0]        composed_next;

  fwc_config #(
    .MAX_WIDTH_BYTES(MAX_WIDTH_BYTES),
    .MAX_HEIGHT     (MAX_HEIGHT)
  ) u_config (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  // Ready chain: a stage advances when empty or when its successor moves
  assign out_ready = !dst_valid || !dst_stall;
  assign s3_ready  = !s3_valid || out_ready;
  assign s2_ready  = !s2_valid || s3_ready;
  assign s1_ready  = !s1_valid || s2_ready;
  assign src_stall = !s1_ready;

  // Base position of the byte's leftmost pixel
  always_comb begin
    unique case (cfg.dir)
      SWEEP_R2L: pos_next = $signed(POS_W'({s1_col, 3'b000}));
      SWEEP_L2R: pos_next = $signed(POS_W'(cfg.width_pix))
                          - $signed(POS_W'(1))
                          - $signed(POS_W'({s1_col, 3'b000}));
      SWEEP_B2T: pos_next = $signed(POS_W'(s1_row));
      SWEEP_T2B: pos_next = $signed(POS_W'(cfg.height_rows))
                          - $signed(POS_W'(1))
                          - $signed(POS_W'(s1_row));
      default:   pos_next = '0;
    endcase
  end

  // Per-pixel compare against the band start and the edge
  always_comb begin
    logic signed [POS_W-1:0] p;
    logic                    before_band;
    logic                    at_edge;
    sel_next = '0;
    for (int i = 0; i < PIX_W; i++) begin
      unique case (cfg.dir)
        SWEEP_R2L: p = s2_pos + $signed(POS_W'(i));
        SWEEP_L2R: p = s2_pos - $signed(POS_W'(i));
        default:   p = s2_pos;
      endcase
      before_band = (p < $signed(POS_W'(cfg.band_start)));
      at_edge     = (p >= $signed(POS_W'({1'b0, cfg.edge_pos})));
      sel_next[PIX_W-1-i] = at_edge
                          || (!before_band && (p[0] == cfg.band_start[0]));
    end
  end

  // Final pick, with the whole-byte cases first
  always_comb begin
    priority if (cfg.edge_zero) begin
      composed_next = s3_new;
    end else if (cfg.edge_past) begin
      composed_next = s3_old;
    end else begin
      composed_next = (s3_new & s3_sel) | (s3_old & ~s3_sel);
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      dst_valid <= 1'b0;
    end else begin
      if (s1_ready)  s1_valid  <= src_valid;
      if (s2_ready)  s2_valid  <= s1_valid;
      if (s3_ready)  s3_valid  <= s2_valid;
      if (out_ready) dst_valid <= s3_valid;
    end
  end

  // Payload registers; hold while stalled
  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_row <= row_index;
      s1_col <= byte_column;
      s1_old <= old_byte;
      s1_new <= new_byte;
    end
    if (s2_ready) begin
      s2_pos <= pos_next;
      s2_old <= s1_old;
      s2_new <= s1_new;
    end
    if (s3_ready) begin
      s3_sel <= sel_next;
      s3_old <= s2_old;
      s3_new <= s2_new;
    end
    if (out_ready) begin
      composed_byte <= composed_next;
    end
  end

  // Input stalls only when the capture stage is full
  assert property (@(posedge clk) disable iff (rst) src_stall |-> s1_valid)
    else $error("src_stall raised with an empty capture stage");

  // An output drops only after it was taken
  assert property (@(posedge clk) disable iff (rst)
    $fell(dst_valid) |-> $past(!dst_stall))
    else $error("result dropped while stalled");

  // Edge at zero passes the new byte through
  assert property (@(posedge clk) disable iff (rst)
    (s3_valid && out_ready && cfg.edge_zero) |=> (composed_byte == $past(s3_new)))
    else $error("edge zero did not give the new byte");

  // Edge past the span passes the old byte through
  assert property (@(posedge clk) disable iff (rst)
    (s3_valid && out_ready && !cfg.edge_zero && cfg.edge_past)
      |=> (composed_byte == $past(s3_old)))
    else $error("edge past span did not give the old byte");

  // A full downstream stage stays full while the output is stalled
  assert property (@(posedge clk) disable iff (rst)
    (s3_valid && dst_valid && dst_stall) |=> s3_valid)
    else $error("stage three lost a request under stall");

endmodule

// ----- test/feathered_wipe_compositor_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// feathered_wipe_compositor_tb
// Streams frame bytes through the wipe compositor under a series of frame
// setups (every sweep direction, oversized and empty frames, wide feathers,
// edges at both ends) and checks each composed byte against a local model
// of the sweep-position and dither rules. Both channels idle and stall in
// random bursts; one long output hold forces the pipe to back up.
// ----------------------------------------------------------------------------
module feathered_wipe_compositor_tb;
  import fwc_pkg::*;

  localparam int MAX_WB      = 128;
  localparam int MAX_H       = 512;
  localparam int CYCLE_LIMIT = 200000;
  localparam int CHOKE_LEN   = 300;
  localparam int RANDOM_REQS = 530;
  localparam int LAST_REQS   = 60;

  // Indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [PIX_W-1:0] oldb;
    logic [PIX_W-1:0] newb;
  } wipe_req_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;
  logic                 src_valid = 1'b0;
  logic                 src_stall;
  logic [ROW_W-1:0]     row_index = '0;
  logic [COL_W-1:0]     byte_column = '0;
  logic [PIX_W-1:0]     old_byte = '0;
  logic [PIX_W-1:0]     new_byte = '0;
  logic                 dst_valid;
  logic                 dst_stall = 1'b0;
  logic [PIX_W-1:0]     composed_byte;

  // Local copy of the frame setup
  logic [EDGE_W-1:0]    wipe_edge_r = '0;
  logic [FEATHER_W-1:0] feather_r = '0;
  sweep_dir_t           dir_r = SWEEP_R2L;
  logic [WBYTES_W-1:0]  wbytes_r = WBYTES_RESET;
  logic [HEIGHT_W-1:0]  height_r = HEIGHT_RESET;

  wipe_req_t        pending_reqs[$];
  logic [PIX_W-1:0] expected_bytes[$];

  int  err_count = 0;
  int  cycle_count = 0;
  bit  idle_on = 1'b1;
  bit  choke_wanted = 1'b0;
  bit  choke_used = 1'b0;
  int  gap_left = 0;
  int  stall_left = 0;
  int  choke_left = 0;

  feathered_wipe_compositor i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .src_valid    (src_valid),
    .src_stall    (src_stall),
    .row_index    (row_index),
    .byte_column  (byte_column),
    .old_byte     (old_byte),
    .new_byte     (new_byte),
    .dst_valid    (dst_valid),
    .dst_stall    (dst_stall),
    .composed_byte(composed_byte)
  );

  always #5 clk = ~clk;

  // Frame width in pixels and height in rows after saturation
  function automatic int frame_w_pix();
    int wb;
    wb = wbytes_r;
    if (wb > MAX_WB) wb = MAX_WB;
    return wb * 8;
  endfunction

  function automatic int frame_h_rows();
    int h;
    h = height_r;
    if (h > MAX_H) h = MAX_H;
    return h;
  endfunction

  function automatic int sweep_span();
    return (dir_r == SWEEP_R2L || dir_r == SWEEP_L2R) ? frame_w_pix() : frame_h_rows();
  endfunction

  // Compose one byte from the sweep position of each pixel
  function automatic logic [PIX_W-1:0] compose_byte(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col,
                                                   input logic [PIX_W-1:0] oldb,
                                                   input logic [PIX_W-1:0] newb);
    int w, h, r, c, edge_i, band, x, pos;
    logic [PIX_W-1:0] res;
    logic [PIX_W-1:0] mask;
    w = frame_w_pix();
    h = frame_h_rows();
    r = row;
    c = col;
    edge_i = wipe_edge_r;
    band = edge_i - int'(feather_r);
    res = '0;
    if (edge_i == 0) return newb;
    if (edge_i >= sweep_span()) return oldb;
    for (int i = 0; i < 8; i++) begin
      mask = PIX_MSB >> i;
      x = c * 8 + i;
      case (dir_r)
        SWEEP_R2L: pos = x;
        SWEEP_L2R: pos = w - 1 - x;
        SWEEP_B2T: pos = r;
        default:   pos = h - 1 - r;
      endcase
      if (pos < band)
        res |= oldb & mask;
      else if (pos >= edge_i)
        res |= newb & mask;
      else if (((pos - band) & 1) == 0)
        res |= newb & mask;
      else
        res |= oldb & mask;
    end
    return res;
  endfunction

  // Write one register and mirror it locally; spare indexes are dropped
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_DAT_W-1:0];
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_WIPE_EDGE:   wipe_edge_r = val[EDGE_W-1:0];
      REG_FEATHER:     feather_r = val[FEATHER_W-1:0];
      REG_DIRECTION:   dir_r = sweep_dir_t'(val[1:0]);
      REG_WIDTH_BYTES: wbytes_r = val[WBYTES_W-1:0];
      REG_HEIGHT:      height_r = val[HEIGHT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_frame(input int edge_v, input int feather_v, input sweep_dir_t dir_v,
                           input int wb_v, input int h_v);
    write_reg(REG_WIPE_EDGE, edge_v);
    write_reg(REG_FEATHER, feather_v);
    write_reg(REG_DIRECTION, dir_v);
    write_reg(REG_WIDTH_BYTES, wb_v);
    write_reg(REG_HEIGHT, h_v);
  endtask

  task automatic add_req(input int row, input int col, input int oldb, input int newb);
    wipe_req_t req;
    req.row  = row[ROW_W-1:0];
    req.col  = col[COL_W-1:0];
    req.oldb = oldb[PIX_W-1:0];
    req.newb = newb[PIX_W-1:0];
    pending_reqs.push_back(req);
  endtask

  // Hold off until every request is taken and every result is back
  task automatic drain();
    while (pending_reqs.size() != 0 || src_valid || expected_bytes.size() != 0)
      @(posedge clk);
  endtask

  // Random frame setup, mostly with the edge inside the span
  task automatic pick_random_frame();
    int wb, h, span, feather_v, edge_v;
    sweep_dir_t dir_v;
    dir_v = sweep_dir_t'($urandom_range(0, 3));
    case ($urandom_range(0, 9))
      0:       wb = 0;
      1:       wb = $urandom_range(MAX_WB + 1, 255);
      default: wb = $urandom_range(1, MAX_WB);
    endcase
    case ($urandom_range(0, 9))
      0:       h = 0;
      1:       h = $urandom_range(MAX_H + 1, 1023);
      default: h = $urandom_range(1, MAX_H);
    endcase
    if (dir_v == SWEEP_R2L || dir_v == SWEEP_L2R)
      span = (wb > MAX_WB ? MAX_WB : wb) * 8;
    else
      span = h > MAX_H ? MAX_H : h;
    feather_v = ($urandom_range(0, 9) == 0) ? $urandom_range(65, 127) : $urandom_range(0, 64);
    case ($urandom_range(0, 9))
      0:       edge_v = 0;
      1:       edge_v = span + $urandom_range(0, 8);
      2:       edge_v = $urandom_range(0, 2047);
      default: edge_v = span > 1 ? $urandom_range(1, span - 1) : 1;
    endcase
    set_frame(edge_v, feather_v, dir_v, wb, h);
  endtask

  // Random requests, most aimed at pixels around the feather band
  task automatic add_random_reqs(input int n);
    int target, row, col, x;
    for (int k = 0; k < n; k++) begin
      row = $urandom_range(0, 511);
      col = $urandom_range(0, 127);
      if ($urandom_range(0, 4) != 0) begin
        target = int'(wipe_edge_r) - int'(feather_r) - 8 + $urandom_range(0, feather_r + 16);
        if (dir_r == SWEEP_R2L || dir_r == SWEEP_L2R) begin
          x = (dir_r == SWEEP_R2L) ? target : frame_w_pix() - 1 - target;
          col = x < 0 ? 0 : (x / 8 > 127 ? 127 : x / 8);
        end else begin
          row = (dir_r == SWEEP_B2T) ? target : frame_h_rows() - 1 - target;
          row = row < 0 ? 0 : (row > 511 ? 511 : row);
        end
      end
      add_req(row, col, $urandom_range(0, 255), $urandom_range(0, 255));
    end
  endtask

  // Request driver: log each taken request, then offer the next or idle
  always @(posedge clk) begin : drive_src
    wipe_req_t req;
    if (rst) begin
      src_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (src_valid && !src_stall)
        expected_bytes.push_back(compose_byte(row_index, byte_column, old_byte, new_byte));
      if (!src_valid || !src_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          src_valid <= 1'b0;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
          gap_left = $urandom_range(0, 13);
          src_valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          req = pending_reqs.pop_front();
          row_index   <= req.row;
          byte_column <= req.col;
          old_byte    <= req.oldb;
          new_byte    <= req.newb;
          src_valid   <= 1'b1;
        end else begin
          src_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each taken byte, then pick the next stall
  always @(posedge clk) begin : watch_dst
    logic [PIX_W-1:0] want;
    if (rst) begin
      dst_stall <= 1'b0;
    end else begin
      if (dst_valid && !dst_stall) begin
        if (expected_bytes.size() == 0) begin
          $error("composed_byte: no result expected, got %02h", composed_byte);
          err_count++;
        end else begin
          want = expected_bytes.pop_front();
          if (composed_byte !== want) begin
            $error("composed_byte: expected %02h, actual %02h", want, composed_byte);
            err_count++;
          end
        end
      end
      if (choke_wanted && !choke_used && dst_valid) begin
        choke_used = 1'b1;
        choke_left = CHOKE_LEN - 1;
        dst_stall <= 1'b1;
      end else if (choke_left > 0) begin
        choke_left--;
        dst_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        dst_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 13);
        dst_stall <= 1'b1;
      end else begin
        dst_stall <= 1'b0;
      end
    end
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("feathered_wipe_compositor_tb: errors");
      $finish;
    end
  end

  initial begin
    int reqs_left, n, phase_n;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Reset setup has edge zero: new page everywhere
    add_req(0, 0, 8'h00, 8'hFF);
    add_req(511, 127, 8'hFF, 8'h00);
    add_req(256, 64, 8'hA5, 8'h5A);
    drain();

    // Spare indexes must leave the setup untouched
    write_reg(REG_SPARE_LO, 2047);
    write_reg(REG_SPARE_HI, 1365);
    add_req(300, 10, 8'h0F, 8'hF0);
    drain();

    // Narrow frame, band straddling the first byte, column outside the frame
    set_frame(8, 4, SWEEP_R2L, 2, 4);
    add_req(0, 0, 8'h00, 8'hFF);
    add_req(3, 1, 8'hFF, 8'h00);
    add_req(511, 127, 8'h00, 8'hFF);
    drain();

    // Oversized width, widest feather, mirrored sweep
    set_frame(1023, 127, SWEEP_L2R, 255, 480);
    add_req(0, 0, 8'h00, 8'hFF);
    add_req(100, 15, 8'hFF, 8'h00);
    add_req(200, 127, 8'h00, 8'hFF);
    drain();

    // Feather wider than the edge, oversized height
    set_frame(5, 9, SWEEP_B2T, 100, 1023);
    add_req(0, 0, 8'h00, 8'hFF);
    add_req(1, 5, 8'h00, 8'hFF);
    add_req(4, 9, 8'hFF, 8'h00);
    add_req(511, 127, 8'h00, 8'hFF);
    drain();

    // Empty frame with a nonzero edge keeps the old page
    set_frame(1, 0, SWEEP_T2B, 100, 0);
    add_req(0, 0, 8'h3C, 8'hC3);
    add_req(511, 127, 8'hC3, 8'h3C);
    drain();

    // Downward sweep with a row past the bottom of the frame
    set_frame(6, 3, SWEEP_T2B, 100, 10);
    add_req(511, 0, 8'h00, 8'hFF);
    add_req(2, 50, 8'h00, 8'hFF);
    add_req(5, 127, 8'h00, 8'hFF);
    drain();

    // Edge at its top value, then an empty frame with edge zero
    set_frame(2047, 64, SWEEP_R2L, 128, 512);
    add_req(17, 77, 8'h55, 8'hAA);
    drain();
    set_frame(0, 64, SWEEP_R2L, 0, 512);
    add_req(17, 77, 8'h55, 8'hAA);
    drain();

    // Random setups; the second one gets a long output hold
    reqs_left = RANDOM_REQS;
    phase_n = 0;
    while (reqs_left > LAST_REQS) begin
      pick_random_frame();
      n = (phase_n == 1) ? 40 : $urandom_range(10, 40);
      if (n > reqs_left - LAST_REQS) n = reqs_left - LAST_REQS;
      if (phase_n == 1) choke_wanted = 1'b1;
      add_random_reqs(n);
      drain();
      reqs_left -= n;
      phase_n++;
    end

    // Last stretch at full rate
    idle_on = 1'b0;
    pick_random_frame();
    add_random_reqs(reqs_left);
    drain();
    repeat (10) @(posedge clk);

    if (err_count == 0)
      $display("feathered_wipe_compositor_tb: clean");
    else
      $display("feathered_wipe_compositor_tb: errors");
    $finish;
  end

endmodule

// ----- files.f -----
src/fwc_pkg.sv
src/fwc_config.sv
src/feathered_wipe_compositor.sv
test/feathered_wipe_compositor_tb.sv
